// ===== sv/task_load_monitor_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the task load monitor
// ---------------------------------------------------------------------------
`ifndef TASK_LOAD_MONITOR_CORE_DEFINES_SVH
`define TASK_LOAD_MONITOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TLM_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TLM_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TLM_ASSERT_IMP(label, a, c)
`define TLM_ASSERT_NXT(label, a, c)
`endif
`endif

// ===== sv/tlm_pkg.sv =====
// ---------------------------------------------------------------------------
// Task load monitor package
// Shared types, constants and controller/datapath interface.
// ---------------------------------------------------------------------------
package tlm_pkg;
  localparam int SLOTS = 16;
  localparam int HISTORY_DEPTH = 10;
  localparam int TIME_WIDTH = 32;
  localparam int SW = $clog2(SLOTS);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [9:0] LOAD_FULL = 10'd1000;
  localparam logic [19:0] AGE_LIMIT = 20'd999999;
  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;
  localparam int QW = TIME_WIDTH + 10;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0, OP_RELEASE = 3'd1, OP_ACCOUNT = 3'd2,
    OP_PERIOD = 3'd3, OP_QUERY = 3'd4, OP_FIND = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] task_handle;
    logic [31:0] run_time;
    logic [31:0] total_time;
    logic [3:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [9:0]  load_now;
    logic [9:0]  load_avg;
    logic [9:0]  load_max;
    logic [19:0] age;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CLEAR, S_PSLOT, S_MUL, S_DIV, S_WB, S_PNEXT,
    S_QSUM, S_QDIV, S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_alloc;
    logic do_release;
    logic do_account;
    logic clr_step;
    logic pslot_init;
    logic pslot_inc;
    logic mul_start;
    logic div_start;
    logic div_step;
    logic wb;
    logic ring_adv;
    logic q_init;
    logic q_step;
    logic qdiv_start;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pslot_last;
    logic       pslot_upd;
    logic       div_done;
    logic       clr_done;
    logic       q_last;
    logic       alloc_ok;
    logic       query_ok;
  } sts_t;
endpackage

// ===== sv/tlm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Task load monitor controller
// Sequences allocate clearing, period walk, division and query averaging.
// ---------------------------------------------------------------------------
module tlm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output tlm_pkg::ctl_t ctl,
  input  tlm_pkg::sts_t sts
);
  import tlm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.op)
          OP_ALLOC:  state_nxt = sts.alloc_ok ? S_CLEAR : S_DONE;
          OP_PERIOD: state_nxt = S_PSLOT;
          OP_QUERY:  state_nxt = sts.query_ok ? S_QSUM : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: if (sts.clr_done) state_nxt = S_DONE;
      S_PSLOT: state_nxt = sts.pslot_upd ? S_MUL : S_PNEXT;
      S_MUL: state_nxt = S_DIV;
      S_DIV: if (sts.div_done) state_nxt = S_WB;
      S_WB: state_nxt = S_PNEXT;
      S_PNEXT: state_nxt = sts.pslot_last ? S_DONE : S_PSLOT;
      S_QSUM: if (sts.q_last) state_nxt = S_QDIV;
      S_QDIV: if (sts.div_done) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state_r != S_IDLE);
    done = (state_r == S_DONE);
    case (state_r)
      S_IDLE: ctl.load_in = start;
      S_DISPATCH: begin
        ctl.do_alloc = (sts.op == OP_ALLOC);
        ctl.do_release = (sts.op == OP_RELEASE);
        ctl.do_account = (sts.op == OP_ACCOUNT);
        ctl.pslot_init = (sts.op == OP_PERIOD);
        ctl.q_init = (sts.op == OP_QUERY);
      end
      S_CLEAR: ctl.clr_step = 1'b1;
      S_PSLOT: ctl.mul_start = sts.pslot_upd;
      S_MUL: ctl.div_start = 1'b1;
      S_DIV: ctl.div_step = 1'b1;
      S_WB: ctl.wb = 1'b1;
      S_PNEXT: begin
        ctl.pslot_inc = 1'b1;
        ctl.ring_adv = sts.pslot_last;
      end
      S_QSUM: begin
        ctl.q_step = 1'b1;
        ctl.qdiv_start = sts.q_last;
      end
      S_QDIV: ctl.div_step = 1'b1;
      S_DONE: ctl.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== sv/tlm_datapath.sv =====
// ---------------------------------------------------------------------------
// Task load monitor datapath
// Slot tables, history memory, multiplier and shared restoring divider.
// ---------------------------------------------------------------------------
module tlm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tlm_pkg::in_item_t   in_item,
  input  tlm_pkg::ctl_t       ctl,
  output tlm_pkg::sts_t       sts,
  output tlm_pkg::out_item_t  out_item
);
  import tlm_pkg::*;

  in_item_t item_r;
  logic [SLOTS-1:0] used_r;
  logic [31:0] handle_r [SLOTS];
  logic [TIME_WIDTH-1:0] acc_r [SLOTS];
  logic [9:0] last_r [SLOTS];
  logic [9:0] peak_r [SLOTS];
  logic [19:0] age_r [SLOTS];
  logic [15:0] hist_mem [SLOTS*HISTORY_DEPTH];
  logic [HW-1:0] ring_r;
  logic [SW-1:0] sel_r;
  logic [SW:0] ps_r;
  logic [HW:0] hc_r;
  out_item_t res_r;
  logic [QW-1:0] prod_r;
  logic [QW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [TIME_WIDTH-1:0] den_r;
  logic [6:0] dcnt_r;
  logic [14:0] qsum_r;
  logic [HCW-1:0] qcnt_r;
  logic [15:0] hrd_r;
  logic hrd_v_r;

  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] free_v;
  logic [SW-1:0] hit_idx, free_idx;
  logic hit, has_free;
  logic [TIME_WIDTH-1:0] tot;
  logic [SW-1:0] ps_idx;
  logic [QW:0] trial;
  logic [9:0] load_sat;
  logic [$clog2(SLOTS*HISTORY_DEPTH)-1:0] waddr, raddr;
  logic [TIME_WIDTH:0] acc_sum;

  assign tot = item_r.total_time[TIME_WIDTH-1:0];
  assign ps_idx = ps_r[SW-1:0];

  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = SLOTS-1; i >= 0; i--) begin
      match[i] = used_r[i] && (handle_r[i] == item_r.task_handle);
      free_v[i] = !used_r[i];
      if (match[i]) begin hit = 1'b1; hit_idx = SW'(i); end
      if (free_v[i]) begin has_free = 1'b1; free_idx = SW'(i); end
    end
  end

  assign sts.op = item_r.operation;
  assign sts.alloc_ok = has_free;
  assign sts.query_ok = ({1'b0, item_r.slot_index} < 5'(SLOTS)) &&
                        used_r[item_r.slot_index[SW-1:0]];
  assign sts.pslot_last = (ps_r == (SW+1)'(SLOTS-1));
  assign sts.pslot_upd = (tot != '0) && used_r[ps_idx];
  assign sts.div_done = (dcnt_r == '0);
  assign sts.clr_done = (hc_r == (HW+1)'(HISTORY_DEPTH-1));
  assign sts.q_last = (hc_r == (HW+1)'(HISTORY_DEPTH));

  assign trial = {rem_r, quo_r[QW-1]} - {1'b0, (QW-TIME_WIDTH)'(0), den_r};
  assign load_sat = (quo_r > QW'(LOAD_FULL)) ? LOAD_FULL : quo_r[9:0];
  assign acc_sum = {1'b0, acc_r[hit_idx]} + {1'b0, item_r.run_time[TIME_WIDTH-1:0]};

  always_comb begin
    waddr = '0;
    if (ctl.clr_step)
      waddr = $bits(waddr)'(sel_r * HISTORY_DEPTH + hc_r[HW-1:0]);
    else
      waddr = $bits(waddr)'(ps_idx * HISTORY_DEPTH + ring_r);
    raddr = $bits(raddr)'(sel_r * HISTORY_DEPTH + hc_r[HW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) hist_mem[waddr] <= EMPTY_MARK;
    else if (ctl.wb) hist_mem[waddr] <= {6'd0, load_sat};
    hrd_r <= hist_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ring_r <= '0;
      hrd_v_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      if (ctl.load_in) begin
        item_r <= in_item;
        res_r <= '0;
      end
      if (ctl.do_alloc) begin
        if (has_free) begin
          used_r[free_idx] <= 1'b1;
          handle_r[free_idx] <= item_r.task_handle;
          acc_r[free_idx] <= '0;
          last_r[free_idx] <= '0;
          peak_r[free_idx] <= '0;
          age_r[free_idx] <= '0;
          sel_r <= free_idx;
          res_r.slot <= 4'(free_idx);
        end else res_r.status <= ST_FULL;
        hc_r <= '0;
      end
      if (ctl.clr_step) hc_r <= hc_r + 1'b1;
      if (ctl.do_release || ctl.do_account || (ctl.q_init == 1'b0 &&
          item_r.operation == OP_FIND && ctl.pslot_init == 1'b0 &&
          ctl.do_alloc == 1'b0 && !ctl.load_in && !ctl.finish &&
          !ctl.clr_step && !ctl.wb && !ctl.div_step && !ctl.q_step &&
          !ctl.mul_start && !ctl.div_start && !ctl.pslot_inc)) begin
        if (hit) res_r.slot <= 4'(hit_idx);
        else res_r.status <= ST_NOT_FOUND;
      end
      if (ctl.do_release && hit) used_r[hit_idx] <= 1'b0;
      if (ctl.do_account && hit)
        acc_r[hit_idx] <= acc_sum[TIME_WIDTH] ? '1 : acc_sum[TIME_WIDTH-1:0];
      if (ctl.pslot_init) ps_r <= '0;
      if (ctl.pslot_inc) begin
        ps_r <= ps_r + 1'b1;
        acc_r[ps_idx] <= '0;
      end
      if (ctl.ring_adv)
        ring_r <= (ring_r == HW'(HISTORY_DEPTH-1)) ? '0 : ring_r + 1'b1;
      if (ctl.mul_start) prod_r <= QW'(acc_r[ps_idx]) * QW'(1000);
      if (ctl.div_start) begin
        quo_r <= prod_r;
        rem_r <= '0;
        den_r <= tot;
        dcnt_r <= 7'(QW);
      end
      if (ctl.div_step && dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 1'b1;
        if (!trial[QW]) begin
          rem_r <= trial[QW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[QW-2:0], quo_r[QW-1]};
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
      end
      if (ctl.wb) begin
        last_r[ps_idx] <= load_sat;
        if (load_sat > peak_r[ps_idx]) peak_r[ps_idx] <= load_sat;
        if (age_r[ps_idx] < AGE_LIMIT) age_r[ps_idx] <= age_r[ps_idx] + 1'b1;
      end
      if (ctl.q_init) begin
        res_r.slot <= item_r.slot_index;
        if (sts.query_ok) begin
          sel_r <= item_r.slot_index[SW-1:0];
          res_r.load_now <= last_r[item_r.slot_index[SW-1:0]];
          res_r.load_max <= peak_r[item_r.slot_index[SW-1:0]];
          res_r.age <= age_r[item_r.slot_index[SW-1:0]];
        end else res_r.status <= ST_EMPTY;
        hc_r <= '0;
        qsum_r <= '0;
        qcnt_r <= '0;
        hrd_v_r <= 1'b0;
      end
      if (ctl.q_step) begin
        hc_r <= hc_r + 1'b1;
        hrd_v_r <= 1'b1;
        if (hrd_v_r && hrd_r != EMPTY_MARK) begin
          qsum_r <= qsum_r + 15'(hrd_r);
          qcnt_r <= qcnt_r + 1'b1;
        end
      end
      if (ctl.qdiv_start) begin
        quo_r <= QW'(qsum_r) + ((hrd_r != EMPTY_MARK) ? QW'(hrd_r) : '0);
        rem_r <= '0;
        den_r <= TIME_WIDTH'(qcnt_r) + ((hrd_r != EMPTY_MARK) ? 1'b1 : 1'b0);
        dcnt_r <= 7'(QW);
      end
      if (ctl.finish && item_r.operation == OP_QUERY && sts.query_ok)
        res_r.load_avg <= (den_r == '0) ? 10'd0 : quo_r[9:0];
    end
  end

  always_comb begin
    out_item = res_r;
    if (ctl.finish && item_r.operation == OP_QUERY && sts.query_ok)
      out_item.load_avg = (den_r == '0) ? 10'd0 : quo_r[9:0];
  end
endmodule

// ===== sv/task_load_monitor_core.sv =====
// ---------------------------------------------------------------------------
// Task load monitor core
// Per-task permille load tracking over a table of task slots.
// ---------------------------------------------------------------------------
// Usage: drive in_item and raise start while busy is low; the item is taken
// on that edge. The result appears on out_item for one cycle with out_valid
// high; the receiver cannot stall and must take it then.
// Sequence per operation code:
//   allocate: history row cleared one entry a cycle
//   release, account, find, unknown: handled at dispatch
//   period end: slots walked in turn, each used slot's load computed by
//     the bit-serial restoring divider shared across slots
//   query: history walk, then divider
// One item is in work at a time; busy stays high until the result strobe.
// Reset empties the slot table and zeroes the ring position; history rows
// are written at allocate, so no clearing pass is run.
// ---------------------------------------------------------------------------
`include "task_load_monitor_core_defines.svh"
module task_load_monitor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tlm_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tlm_pkg::out_item_t  out_item
);
  import tlm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tlm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(out_valid), .ctl(ctl), .sts(sts)
  );

  tlm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl),
    .sts(sts), .out_item(out_item)
  );

  `TLM_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `TLM_ASSERT_NXT(a_done_idle, out_valid, !busy)
  `TLM_ASSERT_IMP(a_done_busy, out_valid, busy)
endmodule
